>>> sv/dts_pkg.sv
// Shared types and constants for the detuned tilted sawtooth oscillator.
package dts_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_BUZZ_MODE   = 3'd0;
  localparam logic [2:0] REG_DETUNE_MODE = 3'd1;
  localparam logic [2:0] REG_VOLUME      = 3'd2;
  localparam logic [2:0] REG_PHASE_STEP  = 3'd3;
  localparam logic [2:0] REG_DETUNE_STEP = 3'd4;

  // Detune mode that doubles the detuned phase.
  localparam logic [1:0] DETUNE_OCTAVE = 2'd2;

  // Ramp shape.
  localparam logic [15:0] TURN_BUZZ   = 16'hefff;
  localparam logic [15:0] TURN_NORMAL = 16'hdfff;
  localparam logic [14:0] RAMP_PEAK   = 15'h5ffc;
  localparam logic [15:0] RAMP_MID    = 16'h2ffe;

  // Rising ramp divides by 0xf000 = 4096*15 or 0xe000 = 8192*7.
  localparam logic [21:0] RECIP_15 = 22'd1118481; // floor(2^24 / 15)
  localparam logic [21:0] RECIP_7  = 22'd2396745; // floor(2^24 / 7)
  localparam int          RAMP_RECIP_SHIFT = 24;

  // Output scale divides by 3072 = 1024*3.
  localparam logic [18:0] RECIP_3 = 19'd349525;   // floor(2^20 / 3)
  localparam int          MIX_RECIP_SHIFT = 20;

  // Per-stage load enables of the sample pipeline.
  typedef struct packed {
    logic st1;
    logic st2;
    logic st3;
    logic st4;
    logic st5;
    logic st6;
  } stage_load_t;

endpackage

>>> sv/dts_ramp.sv
// Tilted sawtooth ramp for one voice: two register stages plus final correction.
module dts_ramp (
  input  logic                clk,
  input  dts_pkg::stage_load_t ld,
  input  logic                buzz,
  input  logic [15:0]         phase,
  output logic [14:0]         amp
);
  import dts_pkg::*;

  logic [15:0] turn;
  logic        rise_c;
  logic [15:0] mag_c;
  logic [30:0] prod1_c;

  logic        rise1;
  logic [30:0] prod1;

  logic [18:0] y_c;
  logic [21:0] recip_c;
  logic [40:0] prod2_c;

  logic        rise2;
  logic [18:0] y2;
  logic [40:0] prod2;

  logic [16:0] q0;
  logic [4:0]  divisor;
  logic [21:0] qd;
  logic [21:0] rem;
  logic [16:0] quot;

  // Pick the rising or falling side and scale by the ramp peak.
  always_comb begin
    turn    = buzz ? TURN_BUZZ : TURN_NORMAL;
    rise_c  = (phase <= turn);
    mag_c   = rise_c ? phase : ~phase;
    prod1_c = 31'(mag_c) * 31'(RAMP_PEAK);
  end

  always_ff @(posedge clk) begin
    if (ld.st1) begin
      rise1 <= rise_c;
      prod1 <= prod1_c;
    end
  end

  // Power-of-two part of the divisor, then the reciprocal product.
  always_comb begin
    y_c     = buzz ? prod1[30:12] : {1'b0, prod1[30:13]};
    recip_c = buzz ? RECIP_15 : RECIP_7;
    prod2_c = 41'(y_c) * 41'(recip_c);
  end

  always_ff @(posedge clk) begin
    if (ld.st2) begin
      rise2 <= rise1;
      y2    <= y_c;
      prod2 <= prod2_c;
    end
  end

  // The reciprocal quotient is exact or one low; a single compare fixes it.
  always_comb begin
    q0      = prod2[40:RAMP_RECIP_SHIFT];
    divisor = buzz ? 5'd15 : 5'd7;
    qd      = 22'(q0) * 22'(divisor);
    rem     = 22'(y2) - qd;
    quot    = (rem >= 22'(divisor)) ? q0 + 17'd1 : q0;
    amp     = rise2 ? quot[14:0] : y2[14:0];
  end

endmodule

>>> sv/dts_mix.sv
// Mixes the two ramps, applies the volume gain and divides by 3072.
module dts_mix (
  input  logic                clk,
  input  dts_pkg::stage_load_t ld,
  input  logic [11:0]         volume,
  input  logic [14:0]         amp_main,
  input  logic [14:0]         amp_det,
  output logic [15:0]         sample
);
  import dts_pkg::*;

  logic signed [15:0] dm_c;
  logic signed [15:0] dd_c;
  logic signed [15:0] half_c;
  logic signed [16:0] pregain;

  logic [13:0]        vol3;
  logic [12:0]        gain;
  logic signed [30:0] scaled;

  logic        neg_c;
  logic [30:0] mag_c;
  logic [20:0] y_c;
  logic        neg;
  logic [20:0] y5;
  logic [39:0] prod5;

  logic [19:0] q0;
  logic [21:0] rem;
  logic [19:0] quot;
  logic [15:0] res_c;

  // Center both ramps; the detuned one is halved, truncating toward zero.
  always_comb begin
    dm_c   = signed'({1'b0, amp_main}) - signed'(RAMP_MID);
    dd_c   = signed'({1'b0, amp_det}) - signed'(RAMP_MID);
    half_c = (dd_c + signed'(16'(dd_c[15]))) >>> 1;
  end

  always_ff @(posedge clk) begin
    if (ld.st3) begin
      pregain <= 17'(dm_c) + 17'(half_c);
    end
  end

  // Gain is volume*3/2, truncated.
  always_comb begin
    vol3 = 14'(volume) + {1'b0, volume, 1'b0};
    gain = vol3[13:1];
  end

  always_ff @(posedge clk) begin
    if (ld.st4) begin
      scaled <= 31'(pregain) * signed'({18'd0, gain});
    end
  end

  // Divide the magnitude by 1024 with a shift, then by 3 with a reciprocal.
  always_comb begin
    neg_c = scaled[30];
    mag_c = neg_c ? 31'(-scaled) : 31'(scaled);
    y_c   = mag_c[30:10];
  end

  always_ff @(posedge clk) begin
    if (ld.st5) begin
      neg   <= neg_c;
      y5    <= y_c;
      prod5 <= 40'(y_c) * 40'(RECIP_3);
    end
  end

  // Correct the quotient and restore the sign.
  always_comb begin
    q0    = prod5[39:MIX_RECIP_SHIFT];
    rem   = 22'(y5) - (22'(q0) + {1'b0, q0, 1'b0});
    quot  = (rem >= 22'd3) ? q0 + 20'd1 : q0;
    res_c = neg ? 16'(-quot) : quot[15:0];
  end

  always_ff @(posedge clk) begin
    if (ld.st6) begin
      sample <= res_c;
    end
  end

endmodule

>>> sv/detuned_tilted_saw_oscillator.sv
// Two-voice tilted sawtooth oscillator top level: config, phases, pipeline control.
// A sample passes through the phase registers, the ramp stages and the mix stages to the output.
// Throughput: one request per cycle while the output is not held off; seven pipeline stages, each with a valid bit,
// advance independently so bubbles close up while the output waits.
// The phase accumulators are single adders updated on each accepted request.
// Synchronous active-high reset clears configuration, phases and valid bits.
module detuned_tilted_saw_oscillator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        chunk_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] sample
);
  import dts_pkg::*;

  logic        buzz_mode;
  logic [1:0]  detune_mode;
  logic [11:0] volume;
  logic [15:0] phase_step;
  logic [16:0] detune_step;

  logic [15:0] main_phase;
  logic [16:0] detuned_phase;

  logic        accept;
  logic        align;
  logic [16:0] det_cur;
  logic [15:0] det_use;

  logic [15:0] main_ph0;
  logic [15:0] det_ph0;

  logic [6:0]  vld;
  logic [6:0]  load;
  stage_load_t ld;

  logic [14:0] amp_main;
  logic [14:0] amp_det;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      buzz_mode   <= 1'b0;
      detune_mode <= 2'd0;
      volume      <= 12'd0;
      phase_step  <= 16'd0;
      detune_step <= 17'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BUZZ_MODE:   buzz_mode   <= cfg_data[0];
        REG_DETUNE_MODE: detune_mode <= cfg_data[1:0];
        REG_VOLUME:      volume      <= cfg_data[11:0];
        REG_PHASE_STEP:  phase_step  <= cfg_data[15:0];
        REG_DETUNE_STEP: detune_step <= cfg_data;
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or the stage after it loads.
  always_comb begin
    load[6] = !vld[6] || out_ready;
    for (int i = 5; i >= 0; i--) begin
      load[i] = !vld[i] || load[i+1];
    end
    ld.st1 = load[1];
    ld.st2 = load[2];
    ld.st3 = load[3];
    ld.st4 = load[4];
    ld.st5 = load[5];
    ld.st6 = load[6];
  end

  assign in_ready  = load[0];
  assign accept    = in_valid && load[0];
  assign out_valid = vld[6];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (load[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < 7; i++) begin
        if (load[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Realign the detuned phase at a chunk start when both steps match.
  always_comb begin
    align   = chunk_start && ({1'b0, phase_step} == detune_step);
    det_cur = align ? {1'b0, main_phase} : detuned_phase;
    det_use = (detune_mode == DETUNE_OCTAVE) ? {det_cur[14:0], 1'b0} : det_cur[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      main_phase    <= 16'd0;
      detuned_phase <= 17'd0;
    end else if (accept) begin
      main_phase    <= main_phase + phase_step;
      detuned_phase <= det_cur + detune_step;
    end
  end

  // Phases used for this sample.
  always_ff @(posedge clk) begin
    if (load[0]) begin
      main_ph0 <= main_phase;
      det_ph0  <= det_use;
    end
  end

  dts_ramp u_ramp_main (
    .clk   (clk),
    .ld    (ld),
    .buzz  (buzz_mode),
    .phase (main_ph0),
    .amp   (amp_main)
  );

  dts_ramp u_ramp_det (
    .clk   (clk),
    .ld    (ld),
    .buzz  (buzz_mode),
    .phase (det_ph0),
    .amp   (amp_det)
  );

  dts_mix u_mix (
    .clk      (clk),
    .ld       (ld),
    .volume   (volume),
    .amp_main (amp_main),
    .amp_det  (amp_det),
    .sample   (sample)
  );

endmodule

>>> dv/tb_detuned_tilted_saw_oscillator.sv
// Self-checking testbench for the detuned tilted sawtooth oscillator with a sample predictor.
module tb_detuned_tilted_saw_oscillator;
  import dts_pkg::*;

  // Ramp and mix constants used by the sample predictor.
  localparam longint PEAK        = 64'h5ffc;
  localparam longint MID         = 64'h2ffe;
  localparam longint TURN_HI     = 64'hefff;
  localparam longint TURN_LO     = 64'hdfff;
  localparam longint FALL_HI     = 64'h1000;
  localparam longint FALL_LO     = 64'h2000;
  localparam longint RISE_HI     = 64'hf000;
  localparam longint RISE_LO     = 64'he000;
  localparam longint FULL        = 64'hffff;
  localparam longint MIX_DIV     = 3072;
  localparam logic [11:0] VOL_MAX = 12'd3640;
  localparam int     LATENCY     = 6;
  localparam int     CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_BUZZ_MODE;
  logic [16:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        chunk_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] sample;

  // Predictor copy of the configuration and the phase accumulators.
  logic        m_buzz;
  logic [1:0]  m_detune_mode;
  logic [11:0] m_volume;
  logic [15:0] m_phase_step;
  logic [16:0] m_detune_step;
  logic [15:0] m_main_ph;
  logic [16:0] m_det_ph;

  logic [15:0] expected_samples[$];
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_left;
  int          n_mismatch;
  int          n_requests;
  int          n_checked;
  int          n_realign;
  int          n_configs;
  int          cycle_count;

  detuned_tilted_saw_oscillator i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .chunk_start(chunk_start),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample     (sample)
  );

  always #5 clk = ~clk;

  // Run limit in case the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d samples outstanding.",
               cycle_count, expected_samples.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Tilted ramp amplitude for a 16-bit phase.
  function automatic longint tilt_amp(input logic [15:0] ph, input logic buzz);
    longint p;
    p = longint'(ph);
    if (buzz) begin
      if (p > TURN_HI) return ((FULL - p) * PEAK) / FALL_HI;
      return (p * PEAK) / RISE_HI;
    end
    if (p > TURN_LO) return ((FULL - p) * PEAK) / FALL_LO;
    return (p * PEAK) / RISE_LO;
  endfunction

  // Computes the sample for one request and advances the predicted phases.
  function automatic logic [15:0] predict_sample(input logic cs);
    logic [15:0] dph;
    longint      amp;
    longint      damp;
    longint      pregain;
    longint      gain;
    longint      mixed;
    if (cs && ({1'b0, m_phase_step} == m_detune_step)) begin
      m_det_ph = {1'b0, m_main_ph};
      n_realign++;
    end
    dph = (m_detune_mode == DETUNE_OCTAVE) ? {m_det_ph[14:0], 1'b0} : m_det_ph[15:0];
    amp = tilt_amp(m_main_ph, m_buzz);
    damp = tilt_amp(dph, m_buzz);
    pregain = (amp - MID) + (damp - MID) / 2;
    gain = (longint'(m_volume) * 3) / 2;
    mixed = (pregain * gain) / MIX_DIV;
    m_main_ph = m_main_ph + m_phase_step;
    m_det_ph = m_det_ph + m_detune_step;
    return mixed[15:0];
  endfunction

  // Receiver: long hold-off when requested, otherwise random stalls.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each accepted sample with the oldest prediction.
  always @(posedge clk) begin
    logic signed [15:0] exp_s;
    logic signed [15:0] act_s;
    if (!rst && out_valid && out_ready) begin
      act_s = sample;
      if (expected_samples.size() == 0) begin
        $error("sample: expected none, actual %0d", act_s);
        n_mismatch++;
      end else begin
        exp_s = expected_samples.pop_front();
        n_checked++;
        if (exp_s !== act_s) begin
          $error("sample: expected %0d, actual %0d", exp_s, act_s);
          n_mismatch++;
        end
      end
    end
  end

  // Sends one sample request, with random idle cycles ahead of it.
  task automatic send_request(input logic cs);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      chunk_start <= 1'($urandom_range(1));
      @(posedge clk);
    end
    in_valid <= 1'b1;
    chunk_start <= cs;
    do @(posedge clk); while (!in_ready);
    expected_samples.push_back(predict_sample(cs));
    n_requests++;
  endtask

  // Stops sending and waits until every predicted sample has come out.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_samples.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [16:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_BUZZ_MODE:   m_buzz = data[0];
      REG_DETUNE_MODE: m_detune_mode = data[1:0];
      REG_VOLUME:      m_volume = data[11:0];
      REG_PHASE_STEP:  m_phase_step = data[15:0];
      REG_DETUNE_STEP: m_detune_step = data;
      default: ;
    endcase
  endtask

  // Writes all five registers once the block is idle.
  task automatic set_config(input logic buzz, input logic [1:0] dmode,
                            input logic [11:0] vol, input logic [15:0] pstep,
                            input logic [16:0] dstep);
    drain();
    write_reg(REG_BUZZ_MODE, {16'd0, buzz});
    write_reg(REG_DETUNE_MODE, {15'd0, dmode});
    write_reg(REG_VOLUME, {5'd0, vol});
    write_reg(REG_PHASE_STEP, {1'b0, pstep});
    write_reg(REG_DETUNE_STEP, dstep);
    cfg_valid <= 1'b0;
    n_configs++;
  endtask

  // Random configuration: extremes now and then, equal steps often.
  task automatic random_config;
    logic [11:0] vol;
    logic [15:0] pstep;
    logic [16:0] dstep;
    logic [1:0]  dmode;
    case ($urandom_range(5))
      0: vol = 12'd0;
      1: vol = VOL_MAX;
      2: vol = 12'($urandom_range(4095, VOL_MAX + 1));
      default: vol = 12'($urandom_range(VOL_MAX));
    endcase
    pstep = 16'($urandom);
    case ($urandom_range(3))
      0, 1: dstep = {1'b0, pstep};
      2: dstep = {1'b0, pstep} + 17'($urandom_range(64));
      default: dstep = 17'($urandom);
    endcase
    dmode = $urandom_range(1) ? DETUNE_OCTAVE : 2'($urandom_range(3));
    set_config(1'($urandom_range(1)), dmode, vol, pstep, dstep);
  endtask

  // Places the phases on each ramp turnover and its neighbors.
  task automatic test_turnovers;
    logic [15:0] targets[6];
    logic        buzz_at[6];
    logic        buzz;
    logic [15:0] pstep;
    logic [16:0] dstep;
    targets = '{16'hdfff, 16'he000, 16'hefff, 16'hf000, 16'hffff, 16'h0000};
    buzz_at = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
    for (int i = 0; i <= 6; i++) begin
      buzz = (i == 0) ? 1'b0 : buzz_at[i - 1];
      pstep = (i < 6) ? targets[i] - m_main_ph : 16'd0;
      dstep = (i < 6) ? {i[0], targets[i]} - m_det_ph : 17'd0;
      set_config(buzz, 2'd0, VOL_MAX, pstep, dstep);
      send_request(1'b0);
    end
  endtask

  // Realignment only when chunk_start is high and both steps match.
  task automatic test_realign;
    set_config(1'b0, 2'd1, VOL_MAX, 16'h0100, 17'h00a00);
    repeat (2) send_request(1'b0);
    set_config(1'b1, 2'd3, 12'd2000, 16'h0321, 17'h00321);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    set_config(1'b0, DETUNE_OCTAVE, 12'd3000, 16'h0321, 17'h10321);
    send_request(1'b1);
    set_config(1'b1, DETUNE_OCTAVE, 12'd3000, 16'h1111, 17'h01111);
    send_request(1'b1);
    send_request(1'b1);
  endtask

  // Volume extremes, including the range where samples wrap.
  task automatic test_volume_extremes;
    set_config(1'b1, DETUNE_OCTAVE, 12'd4095, 16'h0000 - m_main_ph,
               17'h00000 - m_det_ph);
    send_request(1'b0);
    set_config(1'b1, DETUNE_OCTAVE, 12'd4095, 16'hefff, 17'h17fff);
    send_request(1'b0);
    send_request(1'b0);
    set_config(1'b0, 2'd0, 12'd0, 16'hffff, 17'h1ffff);
    send_request(1'b1);
    set_config(1'b0, 2'd0, VOL_MAX, 16'hffff, 17'h1ffff);
    send_request(1'b0);
    send_request(1'b1);
  endtask

  // Random streams of requests under one idle profile.
  task automatic test_random_stream(input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (5) begin
      random_config();
      repeat (100) send_request($urandom_range(7) == 0);
    end
  endtask

  // Receiver holds off long enough that the pipeline fills and stalls requests.
  task automatic test_backpressure;
    random_config();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 300;
    repeat (60) send_request($urandom_range(3) == 0);
    drain();
    repeat (40) send_request($urandom_range(3) == 0);
  endtask

  initial begin
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 0;
    m_buzz = 1'b0;
    m_detune_mode = 2'd0;
    m_volume = '0;
    m_phase_step = '0;
    m_detune_step = '0;
    m_main_ph = '0;
    m_det_ph = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_turnovers();
    test_realign();
    test_volume_extremes();
    test_random_stream(0, 0);
    test_random_stream(55, 0);
    test_random_stream(0, 55);
    test_random_stream(37, 37);
    test_backpressure();

    // Wait for the last samples and catch any extra ones.
    drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (expected_samples.size() != 0) begin
      $error("sample: %0d expected samples never arrived", expected_samples.size());
      n_mismatch++;
    end

    $display("Run covered %0d requests over %0d register settings, %0d realignments,",
             n_requests, n_configs, n_realign);
    $display("four idle profiles and a long output hold-off; %0d samples checked.",
             n_checked);
    if (n_mismatch == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
